// ----- design/bdq_pkg.sv -----
// Package for the bounded double-ended queue core.
// Holds request kinds, status codes, payload widths and the control structs.
// No dependencies.
package bdq_pkg;

    localparam int KIND_W = 3;
    localparam int STATUS_W = 2;
    localparam int TEXT_BYTES = 20;
    localparam int NUMBER_W = 32;
    localparam int DATA_W = NUMBER_W + TEXT_BYTES * 8;

    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_BACK = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP_BACK = 3'd3;
    localparam logic [KIND_W-1:0] KIND_LIST = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

    typedef struct packed {
        logic op_exec;
        logic list_first;
        logic list_rd;
        logic list_emit;
    } bdq_cmd_t;

    typedef struct packed {
        logic out_free;
        logic count_zero;
        logic list_last;
    } bdq_status_t;

endpackage

// ----- design/bdq_ctrl.sv -----
// Controller for the bounded double-ended queue core.
// Accepts requests and sequences list output; drives the datapath by commands.
// Depends on bdq_pkg.
module bdq_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic [bdq_pkg::KIND_W-1:0]    s_kind,
    output logic                          s_ready,
    input  bdq_pkg::bdq_status_t          dp_status,
    output bdq_pkg::bdq_cmd_t             cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EMIT = 1'b1;

    logic state_reg;
    logic state_next;
    logic accept;

    assign s_ready = aresetn && (state_reg == S_IDLE) && dp_status.out_free;
    assign accept = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (s_kind == bdq_pkg::KIND_LIST && !dp_status.count_zero) begin
                        cmd.list_first = 1'b1;
                        cmd.list_rd = 1'b1;
                        state_next = S_EMIT;
                    end else begin
                        cmd.op_exec = 1'b1;
                    end
                end
            end
            S_EMIT: begin
                if (dp_status.out_free) begin
                    cmd.list_emit = 1'b1;
                    if (dp_status.list_last) begin
                        state_next = S_IDLE;
                    end else begin
                        cmd.list_rd = 1'b1;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- design/bdq_datapath.sv -----
// Datapath for the bounded double-ended queue core.
// Holds the ring store, head index, entry count, list index and result register.
// Depends on bdq_pkg.
module bdq_datapath #(
    parameter int DEPTH = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  bdq_pkg::bdq_cmd_t               cmd,
    output bdq_pkg::bdq_status_t            dp_status,
    input  logic [bdq_pkg::KIND_W-1:0]      in_kind,
    input  logic [bdq_pkg::DATA_W-1:0]      in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [bdq_pkg::STATUS_W-1:0]    out_status,
    output logic [bdq_pkg::DATA_W-1:0]      out_data,
    output logic                            out_last
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = IDX_W + 1;

    logic [bdq_pkg::DATA_W-1:0] mem [DEPTH];
    logic [bdq_pkg::DATA_W-1:0] rdata_reg;

    logic [IDX_W-1:0] head_reg;
    logic [IDX_W-1:0] head_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] rd_index;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;

    logic                             out_valid_reg;
    logic [bdq_pkg::STATUS_W-1:0]     out_status_reg;
    logic [bdq_pkg::DATA_W-1:0]       out_data_reg;
    logic                             out_last_reg;
    logic                             op_load;
    logic [bdq_pkg::STATUS_W-1:0]     op_status;

    logic count_zero;
    logic count_full;

    function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                   input logic [CNT_W-1:0] offset);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(offset);
        if (sum >= SUM_W'(DEPTH)) begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    assign count_zero = (count_reg == '0);
    assign count_full = (count_reg == CNT_W'(DEPTH));

    assign dp_status.out_free = !out_valid_reg || out_ready;
    assign dp_status.count_zero = count_zero;
    assign dp_status.list_last = ((idx_reg + CNT_W'(1)) == count_reg);

    assign rd_index = cmd.list_first ? '0 : (idx_reg + CNT_W'(1));
    assign rd_addr = wrap_add(head_reg, rd_index);

    always_comb begin
        head_next = head_reg;
        count_next = count_reg;
        wr_en = 1'b0;
        wr_addr = wrap_add(head_reg, count_reg);
        op_load = 1'b0;
        op_status = bdq_pkg::STATUS_OK;
        if (cmd.op_exec) begin
            unique case (in_kind)
                bdq_pkg::KIND_PUSH_FRONT, bdq_pkg::KIND_PUSH_BACK: begin
                    op_load = 1'b1;
                    if (count_full) begin
                        op_status = bdq_pkg::STATUS_FULL;
                    end else begin
                        wr_en = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                        if (in_kind == bdq_pkg::KIND_PUSH_FRONT) begin
                            head_next = (head_reg == '0) ? IDX_W'(DEPTH - 1)
                                                         : head_reg - IDX_W'(1);
                            wr_addr = head_next;
                        end
                    end
                end
                bdq_pkg::KIND_POP_FRONT, bdq_pkg::KIND_POP_BACK: begin
                    op_load = 1'b1;
                    if (count_zero) begin
                        op_status = bdq_pkg::STATUS_EMPTY;
                    end else begin
                        count_next = count_reg - CNT_W'(1);
                        if (in_kind == bdq_pkg::KIND_POP_FRONT) begin
                            head_next = wrap_add(head_reg, CNT_W'(1));
                        end
                    end
                end
                bdq_pkg::KIND_LIST: begin
                    op_load = 1'b1;
                    op_status = bdq_pkg::STATUS_EMPTY;
                end
                default: begin
                    op_load = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= in_data;
        end
        if (cmd.list_rd) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            count_reg <= '0;
            idx_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            head_reg <= head_next;
            count_reg <= count_next;
            if (cmd.list_rd) begin
                idx_reg <= rd_index;
            end
            if (op_load || cmd.list_emit) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (op_load) begin
            out_status_reg <= op_status;
            out_data_reg <= '0;
            out_last_reg <= 1'b1;
        end else if (cmd.list_emit) begin
            out_status_reg <= bdq_pkg::STATUS_OK;
            out_data_reg <= rdata_reg;
            out_last_reg <= dp_status.list_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_data = out_data_reg;
    assign out_last = out_last_reg;

endmodule

// ----- design/bounded_double_ended_queue_core.sv -----
// Top level of the bounded double-ended queue core.
// Joins the controller and the datapath; depends on bdq_pkg, bdq_ctrl, bdq_datapath.
//
//   Channel  Direction  Carries
//   s_axis   in         request: kind in tuser, entry to push in tdata
//   m_axis   out        result: status in tuser, listed entry in tdata, tlast on final
//
// A push or pop request gives one result.
// A list request gives one result per stored entry, read one at a time through the
// single read port of the ring store; a list of an empty queue gives one result.
// After reset the queue is empty; the store contents need no clearing.
// A stalled result holds in the output register; requests wait until it can be replaced.
module bounded_double_ended_queue_core #(
    parameter int DEPTH = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: number[31:0], text_a[95:32], text_b[159:96], text_c[191:160]
    input  logic [bdq_pkg::DATA_W-1:0]        s_axis_tdata,
    // tuser: kind[2:0]
    input  logic [bdq_pkg::KIND_W-1:0]        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata: entry_number[31:0], entry_text_a[95:32], entry_text_b[159:96],
    // entry_text_c[191:160]
    output logic [bdq_pkg::DATA_W-1:0]        m_axis_tdata,
    // tuser: status[1:0]
    output logic [bdq_pkg::STATUS_W-1:0]      m_axis_tuser,
    output logic                              m_axis_tlast
);

    bdq_pkg::bdq_cmd_t    cmd;
    bdq_pkg::bdq_status_t dp_status;

    bdq_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_axis_tvalid),
        .s_kind    (s_axis_tuser),
        .s_ready   (s_axis_tready),
        .dp_status (dp_status),
        .cmd       (cmd)
    );

    bdq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .dp_status  (dp_status),
        .in_kind    (s_axis_tuser),
        .in_data    (s_axis_tdata),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_status (m_axis_tuser),
        .out_data   (m_axis_tdata),
        .out_last   (m_axis_tlast)
    );

endmodule

// ----- bench/bdq_result_checker.sv -----
// Result checker for the bounded double-ended queue core.
// Mirrors the deque from accepted requests and compares every result in order.
// Depends on bdq_pkg.
module bdq_result_checker #(
    parameter int DEPTH = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic [bdq_pkg::DATA_W-1:0]     s_axis_tdata,
    input  logic [bdq_pkg::KIND_W-1:0]     s_axis_tuser,
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [bdq_pkg::DATA_W-1:0]     m_axis_tdata,
    input  logic [bdq_pkg::STATUS_W-1:0]   m_axis_tuser,
    input  logic                           m_axis_tlast,
    output int                             fail_count,
    output int                             outstanding
);
    import bdq_pkg::*;

    localparam int REPORT_CAP = 60;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   entry_bits;
        logic                last;
    } deque_reply_t;

    logic [DATA_W-1:0] ring_slots [DEPTH];
    int                front_slot = 0;
    int                live_count = 0;
    int                mismatches = 0;
    deque_reply_t      pending_replies [$];

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        if (mismatches < REPORT_CAP)
            $display("%0t: mismatch on %s, expected %h, got %h", $time, what, want, got);
        mismatches++;
    endtask

    task automatic add_reply(input logic [STATUS_W-1:0] status,
                             input logic [DATA_W-1:0] entry_bits, input logic last);
        deque_reply_t r;
        r.status = status;
        r.entry_bits = entry_bits;
        r.last = last;
        pending_replies.push_back(r);
    endtask

    task automatic apply_request(input logic [KIND_W-1:0] kind,
                                 input logic [DATA_W-1:0] payload);
        int slot;
        case (kind)
            KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
                if (live_count >= DEPTH) begin
                    add_reply(STATUS_FULL, '0, 1'b1);
                end else begin
                    if (kind == KIND_PUSH_FRONT) begin
                        front_slot = (front_slot + DEPTH - 1) % DEPTH;
                        slot = front_slot;
                    end else begin
                        slot = (front_slot + live_count) % DEPTH;
                    end
                    ring_slots[slot] = payload;
                    live_count++;
                    add_reply(STATUS_OK, '0, 1'b1);
                end
            end
            KIND_POP_FRONT, KIND_POP_BACK: begin
                if (live_count == 0) begin
                    add_reply(STATUS_EMPTY, '0, 1'b1);
                end else begin
                    if (kind == KIND_POP_FRONT)
                        front_slot = (front_slot + 1) % DEPTH;
                    live_count--;
                    add_reply(STATUS_OK, '0, 1'b1);
                end
            end
            KIND_LIST: begin
                if (live_count == 0) begin
                    add_reply(STATUS_EMPTY, '0, 1'b1);
                end else begin
                    for (int i = 0; i < live_count; i++)
                        add_reply(STATUS_OK, ring_slots[(front_slot + i) % DEPTH],
                                  i == live_count - 1);
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
            report_mismatch(what, want, got);
    endtask

    task automatic check_result();
        deque_reply_t want;
        if (pending_replies.size() == 0) begin
            report_mismatch("result with no request pending, status", '0, 64'(m_axis_tuser));
        end else begin
            want = pending_replies.pop_front();
            check_field("status", 64'(want.status), 64'(m_axis_tuser));
            check_field("entry_number", 64'(want.entry_bits[31:0]), 64'(m_axis_tdata[31:0]));
            check_field("entry_text_a", want.entry_bits[95:32], m_axis_tdata[95:32]);
            check_field("entry_text_b", want.entry_bits[159:96], m_axis_tdata[159:96]);
            check_field("entry_text_c", 64'(want.entry_bits[191:160]),
                        64'(m_axis_tdata[191:160]));
            check_field("last", 64'(want.last), 64'(m_axis_tlast));
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready)
                apply_request(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                check_result();
        end
        outstanding <= pending_replies.size();
        fail_count <= mismatches;
    end

endmodule

// ----- bench/bounded_double_ended_queue_core_tb.sv -----
// Top of the bounded double-ended queue core testbench.
// Drives directed and random requests with random idling on both channels and gives the
// verdict; depends on bdq_pkg, bdq_result_checker and bounded_double_ended_queue_core.
module bounded_double_ended_queue_core_tb;
    import bdq_pkg::*;

    localparam int DEPTH = 16;
    localparam int RANDOM_REQUESTS = 320;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam logic [KIND_W-1:0] KIND_IGNORED_MIN = 3'd5;
    localparam logic [KIND_W-1:0] KIND_IGNORED_MAX = 3'd7;

    typedef enum {PHASE_FILL, PHASE_DRAIN, PHASE_MIXED} phase_t;

    logic                aclk;
    logic                aresetn = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [DATA_W-1:0]   s_axis_tdata = '0;
    logic [KIND_W-1:0]   s_axis_tuser = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [DATA_W-1:0]   m_axis_tdata;
    logic [STATUS_W-1:0] m_axis_tuser;
    logic                m_axis_tlast;
    int                  fail_count;
    int                  outstanding;
    int                  quiet_cycles = 0;

    bounded_double_ended_queue_core #(.DEPTH(DEPTH)) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    bdq_result_checker #(.DEPTH(DEPTH)) i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            return 0;
        else if (pick < 85)
            return $urandom_range(1, 3);
        else if (pick < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 40);
    endfunction

    function automatic logic [DATA_W-1:0] make_entry(input logic [31:0] number,
                                                     input logic [63:0] text_a,
                                                     input logic [63:0] text_b,
                                                     input logic [31:0] text_c);
        return {text_c, text_b, text_a, number};
    endfunction

    function automatic logic [63:0] text_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] random_entry();
        logic [31:0] number;
        logic [63:0] word_c;
        case ($urandom_range(0, 7))
            0: number = 32'h8000_0000;
            1: number = 32'h7fff_ffff;
            2: number = '0;
            3: number = '1;
            default: number = $urandom;
        endcase
        word_c = text_word();
        return make_entry(number, text_word(), text_word(), word_c[31:0]);
    endfunction

    function automatic logic [KIND_W-1:0] pick_kind(input phase_t phase);
        int p;
        p = $urandom_range(0, 99);
        if (p >= 95)
            return KIND_W'($urandom_range(KIND_IGNORED_MIN, KIND_IGNORED_MAX));
        case (phase)
            PHASE_FILL: begin
                if (p < 35) return KIND_PUSH_FRONT;
                if (p < 70) return KIND_PUSH_BACK;
                if (p < 75) return KIND_POP_FRONT;
                if (p < 80) return KIND_POP_BACK;
                return KIND_LIST;
            end
            PHASE_DRAIN: begin
                if (p < 8) return KIND_PUSH_FRONT;
                if (p < 15) return KIND_PUSH_BACK;
                if (p < 45) return KIND_POP_FRONT;
                if (p < 75) return KIND_POP_BACK;
                return KIND_LIST;
            end
            default: begin
                if (p < 20) return KIND_PUSH_FRONT;
                if (p < 40) return KIND_PUSH_BACK;
                if (p < 55) return KIND_POP_FRONT;
                if (p < 70) return KIND_POP_BACK;
                return KIND_LIST;
            end
        endcase
    endfunction

    // Returns at the edge where the request is taken; valid stays high for a back-to-back one.
    task automatic send_request(input logic [KIND_W-1:0] kind,
                                input logic [DATA_W-1:0] payload, input bit no_gaps);
        int gap;
        gap = no_gaps ? 0 : idle_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= payload;
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    initial begin
        int gap;
        wait (aresetn);
        forever begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(50, 150)) @(posedge aclk);
            else
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            gap = idle_len();
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("bounded_double_ended_queue_core regression: fail");
            $finish;
        end
    end

    initial begin
        int     sent;
        int     len;
        bit     no_gaps;
        phase_t phase;
        logic [KIND_W-1:0] kind;

        sent = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_request(KIND_LIST, random_entry(), 1'b0);
        send_request(KIND_POP_FRONT, random_entry(), 1'b0);
        send_request(KIND_POP_BACK, random_entry(), 1'b0);
        send_request(KIND_PUSH_FRONT, make_entry(32'h8000_0000, '0, '0, '0), 1'b0);
        send_request(KIND_PUSH_BACK, make_entry(32'h7fff_ffff, '1, '1, '1), 1'b0);
        send_request(KIND_PUSH_FRONT, make_entry('1, 64'h0123_4567_89ab_cdef,
                     64'hfedc_ba98_7654_3210, 32'h5a5a_a5a5), 1'b1);
        send_request(KIND_PUSH_BACK, make_entry('0, 64'haaaa_5555_aaaa_5555,
                     64'h5555_aaaa_5555_aaaa, 32'ha5a5_5a5a), 1'b1);
        send_request(KIND_LIST, random_entry(), 1'b1);
        send_request(KIND_POP_FRONT, random_entry(), 1'b0);
        send_request(KIND_POP_BACK, random_entry(), 1'b0);
        send_request(KIND_LIST, random_entry(), 1'b0);
        send_request(KIND_IGNORED_MIN, random_entry(), 1'b0);
        send_request(KIND_W'(KIND_IGNORED_MIN + 1), random_entry(), 1'b1);
        send_request(KIND_IGNORED_MAX, random_entry(), 1'b0);
        send_request(KIND_POP_BACK, random_entry(), 1'b0);
        send_request(KIND_POP_FRONT, random_entry(), 1'b0);
        send_request(KIND_POP_FRONT, random_entry(), 1'b0);
        send_request(KIND_LIST, random_entry(), 1'b0);

        while (sent < RANDOM_REQUESTS) begin
            phase = phase_t'($urandom_range(0, 2));
            len = $urandom_range(10, 40);
            no_gaps = ($urandom_range(0, 3) == 0);
            repeat (len) begin
                kind = pick_kind(phase);
                send_request(kind, random_entry(), no_gaps);
                if (kind <= KIND_LIST)
                    sent++;
            end
        end
        s_axis_tvalid <= 1'b0;

        do @(posedge aclk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0 && outstanding == 0)
            $display("bounded_double_ended_queue_core regression: pass");
        else
            $display("bounded_double_ended_queue_core regression: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
design/bdq_pkg.sv
design/bdq_ctrl.sv
design/bdq_datapath.sv
design/bounded_double_ended_queue_core.sv
bench/bdq_result_checker.sv
bench/bounded_double_ended_queue_core_tb.sv
